/* hdl/bfp_pkg.sv */
package bfp_pkg;

    // Field widths of the request and response transfers.
    localparam int REQ_W   = 3;
    localparam int CNT_W   = 14;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int WIDTH_W = 6;

    // Largest field that one read, write or peek moves.
    localparam logic [WIDTH_W-1:0] MAX_FIELD = 6'd32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ_U = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ_S = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SKIP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_WR = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_RD = 3'd5;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd6;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd7;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERREAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request and launch the store read
        logic commit;   // finish the request and load the response
    } ctrl_cmd_t;

endpackage

/* hdl/bfp_ram.sv */
module bfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hdl/bfp_ctrl.sv */
module bfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bfp_pkg::ctrl_cmd_t cmd
);
    import bfp_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load;
    logic       commit;

    // A request is taken only in idle; it finishes once the response slot is free.
    assign load     = in_valid && (state_reg == ST_IDLE);
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The response stays valid until its transfer completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.load   = load;
    assign cmd.commit = commit;

endmodule

/* hdl/bfp_datapath.sv */
module bfp_datapath #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfp_pkg::ctrl_cmd_t         cmd,
    input  logic [bfp_pkg::REQ_W-1:0]  req_type,
    input  logic [bfp_pkg::CNT_W-1:0]  bit_count,
    input  logic [bfp_pkg::DATA_W-1:0] value,
    input  logic [bfp_pkg::CNT_W-1:0]  position,
    output logic [bfp_pkg::DATA_W-1:0] read_data,
    output logic [bfp_pkg::STAT_W-1:0] status,
    output logic                       overread_seen,
    output logic [bfp_pkg::CNT_W-1:0]  write_pos,
    output logic [bfp_pkg::CNT_W-1:0]  read_pos,
    output logic                       at_end
);
    import bfp_pkg::*;

    localparam int CAP        = BUF_BYTES * 8;
    localparam int PTR_W      = $clog2(CAP + 1);
    localparam int SUM_W      = (PTR_W > CNT_W ? PTR_W : CNT_W) + 1;
    localparam int WI_W       = PTR_W - 5;
    localparam int BANK_DEPTH = (BUF_BYTES + 7) / 8;
    localparam int BANK_AW    = $clog2(BANK_DEPTH > 1 ? BANK_DEPTH : 2);
    localparam logic [SUM_W-1:0] CAP_EXT = SUM_W'(CAP);

    // Pointers and the sticky flag.
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             flag_reg, flag_next;

    // Captured request.
    logic [REQ_W-1:0]  req_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  pos_reg;

    // Response payload.
    logic [DATA_W-1:0] data_reg, data_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    // Store addressing over two 32-bit word banks, even and odd words.
    logic [REQ_W-1:0]   cur_req;
    logic [PTR_W-1:0]   bit_ptr;
    logic [WI_W-1:0]    word_idx;
    logic [WI_W:0]      even_idx;
    logic [4:0]         bit_off;
    logic [BANK_AW-1:0] even_addr, odd_addr;
    logic [DATA_W-1:0]  even_rd, odd_rd, even_wd, odd_wd;
    logic               store_we;

    // Field alignment.
    logic [WIDTH_W-1:0]    width;
    logic [DATA_W-1:0]     field_mask;
    logic [2*DATA_W-1:0]   window;
    logic [2*DATA_W-1:0]   merged;
    logic [2*DATA_W-1:0]   wmask;
    logic [2*DATA_W-1:0]   wval;
    logic [DATA_W-1:0]     field;
    logic [DATA_W-1:0]     field_sx;
    logic                  sign_bit;
    logic [SUM_W-1:0]      wp_ext, rp_ext, cnt_ext, width_ext, pos_ext;
    logic [SUM_W-1:0]      wp_end, rp_end, skip_end, pos_sat;

    // Address from the incoming request while loading, from the held one afterwards.
    assign cur_req   = cmd.load ? req_type : req_reg;
    assign bit_ptr   = (cur_req == REQ_WRITE) ? wp_reg : rp_reg;
    assign word_idx  = bit_ptr[PTR_W-1:5];
    assign bit_off   = bit_ptr[4:0];
    assign even_idx  = {1'b0, word_idx} + (WI_W + 1)'(word_idx[0]);
    assign even_addr = BANK_AW'(even_idx >> 1);
    assign odd_addr  = BANK_AW'(word_idx >> 1);

    bfp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_ram (
        .clk   (clk),
        .we    (store_we),
        .addr  (even_addr),
        .wdata (even_wd),
        .rdata (even_rd)
    );

    bfp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_ram (
        .clk   (clk),
        .we    (store_we),
        .addr  (odd_addr),
        .wdata (odd_wd),
        .rdata (odd_rd)
    );

    // Two consecutive words form a window that holds any field at this pointer.
    assign window = word_idx[0] ? {even_rd, odd_rd} : {odd_rd, even_rd};

    assign width      = (cnt_reg > CNT_W'(MAX_FIELD)) ? MAX_FIELD : cnt_reg[WIDTH_W-1:0];
    assign field_mask = DATA_W'({{DATA_W{1'b0}}, {DATA_W{1'b1}}} >> (MAX_FIELD - width));

    // Read side: shift the field down, then mask and sign extend.
    assign field    = DATA_W'(window >> bit_off) & field_mask;
    assign sign_bit = |(field & (field_mask ^ (field_mask >> 1)));
    assign field_sx = (req_reg == REQ_READ_S && width < MAX_FIELD && sign_bit)
                      ? (field | ~field_mask) : field;

    // Write side: replace the target bits in the window.
    assign wmask  = {{DATA_W{1'b0}}, field_mask} << bit_off;
    assign wval   = {{DATA_W{1'b0}}, val_reg & field_mask} << bit_off;
    assign merged = (window & ~wmask) | (wval & wmask);
    assign even_wd = word_idx[0] ? merged[2*DATA_W-1:DATA_W] : merged[DATA_W-1:0];
    assign odd_wd  = word_idx[0] ? merged[DATA_W-1:0] : merged[2*DATA_W-1:DATA_W];

    // Extended sums for the bounds checks.
    assign wp_ext    = SUM_W'(wp_reg);
    assign rp_ext    = SUM_W'(rp_reg);
    assign cnt_ext   = SUM_W'(cnt_reg);
    assign width_ext = SUM_W'(width);
    assign pos_ext   = SUM_W'(pos_reg);
    assign wp_end    = wp_ext + width_ext;
    assign rp_end    = rp_ext + width_ext;
    assign skip_end  = rp_ext + cnt_ext;
    assign pos_sat   = (pos_ext > CAP_EXT) ? CAP_EXT : pos_ext;

    // Request execution.
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        flag_next = flag_reg;
        data_next = '0;
        stat_next = STAT_OK;
        store_we  = 1'b0;
        case (req_reg)
            REQ_WRITE:
            begin
                if (width != '0)
                begin
                    if (wp_end > CAP_EXT)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        store_we = cmd.commit;
                        wp_next  = PTR_W'(wp_end);
                    end
                end
            end
            REQ_READ_U, REQ_READ_S, REQ_PEEK:
            begin
                if (width != '0)
                begin
                    if (rp_end > wp_ext)
                    begin
                        flag_next = 1'b1;
                        stat_next = STAT_OVERREAD;
                    end
                    else
                    begin
                        data_next = field_sx;
                        if (req_reg != REQ_PEEK)
                        begin
                            rp_next = PTR_W'(rp_end);
                        end
                    end
                end
            end
            REQ_SKIP:
            begin
                if (skip_end > wp_ext)
                begin
                    flag_next = 1'b1;
                    stat_next = STAT_OVERREAD;
                    rp_next   = wp_reg;
                end
                else
                begin
                    rp_next = PTR_W'(skip_end);
                end
            end
            REQ_SET_WR:
            begin
                wp_next = PTR_W'(pos_sat);
            end
            REQ_SET_RD:
            begin
                rp_next = PTR_W'(pos_sat);
            end
            default:
            begin
                // Start over.
                wp_next   = '0;
                rp_next   = '0;
                flag_next = 1'b0;
            end
        endcase
    end

    // Pointer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            flag_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            flag_reg <= flag_next;
        end
    end

    // Request capture and response payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            cnt_reg <= bit_count;
            val_reg <= value;
            pos_reg <= position;
        end
        if (cmd.commit)
        begin
            data_reg <= data_next;
            stat_reg <= stat_next;
        end
    end

    // Pointers change only when a new response is loaded, so they serve as payload.
    assign read_data     = data_reg;
    assign status        = stat_reg;
    assign overread_seen = flag_reg;
    assign write_pos     = wp_ext[CNT_W-1:0];
    assign read_pos      = rp_ext[CNT_W-1:0];
    assign at_end        = (rp_reg >= wp_reg);

endmodule

/* hdl/bit_field_pack_unpack_buffer.sv */
// Channel   Handshake             Payload
// request   in_valid / in_stall   req_type, bit_count, value, position
// response  out_valid / out_stall read_data, status, overread_seen,
//                                 write_pos, read_pos, at_end
//
// Each request reads two 32-bit store words through the registered read port
// of the word banks, then merges or extracts the field and, for a write,
// writes the words back. One response follows each request.
// Reset clears the pointers and the sticky flag; the store is not cleared.
// A stalled response holds the next request in the execute state.
module bit_field_pack_unpack_buffer #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bfp_pkg::REQ_W-1:0]  req_type,
    input  logic [bfp_pkg::CNT_W-1:0]  bit_count,
    input  logic [bfp_pkg::DATA_W-1:0] value,
    input  logic [bfp_pkg::CNT_W-1:0]  position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bfp_pkg::DATA_W-1:0] read_data,
    output logic [bfp_pkg::STAT_W-1:0] status,
    output logic                       overread_seen,
    output logic [bfp_pkg::CNT_W-1:0]  write_pos,
    output logic [bfp_pkg::CNT_W-1:0]  read_pos,
    output logic                       at_end
);
    import bfp_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencing of request and response transfers.
    bfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Store, pointers and field alignment.
    bfp_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .bit_count     (bit_count),
        .value         (value),
        .position      (position),
        .read_data     (read_data),
        .status        (status),
        .overread_seen (overread_seen),
        .write_pos     (write_pos),
        .read_pos      (read_pos),
        .at_end        (at_end)
    );

endmodule

/* tb/sv/bit_field_checker.sv */
// Watches both channels of the bit field buffer, predicts every response from
// the accepted requests and compares each accepted response field by field.
module bit_field_checker #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [bfp_pkg::REQ_W-1:0]  req_type,
    input  logic [bfp_pkg::CNT_W-1:0]  bit_count,
    input  logic [bfp_pkg::DATA_W-1:0] value,
    input  logic [bfp_pkg::CNT_W-1:0]  position,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [bfp_pkg::DATA_W-1:0] read_data,
    input  logic [bfp_pkg::STAT_W-1:0] status,
    input  logic                       overread_seen,
    input  logic [bfp_pkg::CNT_W-1:0]  write_pos,
    input  logic [bfp_pkg::CNT_W-1:0]  read_pos,
    input  logic                       at_end,
    output int unsigned                failures,
    output int unsigned                outstanding
);
    import bfp_pkg::*;

    localparam int CAP_BITS = BUF_BYTES * 8;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic              overread_seen;
        logic [CNT_W-1:0]  write_pos;
        logic [CNT_W-1:0]  read_pos;
        logic              at_end;
    } response_t;

    // Shadow copy of the bit stream and its pointers.
    logic [7:0]  stream_bytes [BUF_BYTES];
    int unsigned wr_bits;
    int unsigned rd_bits;
    logic        sticky_overread;

    response_t   expected_responses [$];
    response_t   expected;
    response_t   observed;
    int unsigned mismatch_count = 0;
    int unsigned response_index = 0;

    assign failures = mismatch_count;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("mismatch at response %0d: %s", response_index, what);
        mismatch_count++;
    endtask

    // Gathers a field LSB first starting at a bit position of the stream.
    function automatic logic [DATA_W-1:0] fetch_field(input int unsigned start,
                                                      input int unsigned width);
        logic [DATA_W-1:0] acc;
        int unsigned       p;
        acc = '0;
        for (int unsigned i = 0; i < width; i++)
        begin
            p = start + i;
            if ((p >> 3) < BUF_BYTES)
            begin
                acc[i] = stream_bytes[p >> 3][p & 7];
            end
        end
        return acc;
    endfunction

    // Replaces the target bits with the low bits of the value.
    function automatic void store_field(input int unsigned start, input int unsigned width,
                                        input logic [DATA_W-1:0] v);
        int unsigned p;
        for (int unsigned i = 0; i < width; i++)
        begin
            p = start + i;
            if ((p >> 3) < BUF_BYTES)
            begin
                stream_bytes[p >> 3][p & 7] = v[i];
            end
        end
    endfunction

    // Applies one request to the shadow state and returns the response it causes.
    function automatic response_t apply_request(input logic [REQ_W-1:0]  req,
                                                input logic [CNT_W-1:0]  cnt,
                                                input logic [DATA_W-1:0] val,
                                                input logic [CNT_W-1:0]  pos);
        int unsigned       width;
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] stat;
        response_t         r;
        width = (cnt > MAX_FIELD) ? MAX_FIELD : cnt;
        data  = '0;
        stat  = STAT_OK;
        case (req)
            REQ_WRITE:
            begin
                if (width != 0)
                begin
                    if (wr_bits + width > CAP_BITS)
                    begin
                        stat = STAT_FULL;
                    end
                    else
                    begin
                        store_field(wr_bits, width, val);
                        wr_bits += width;
                    end
                end
            end
            REQ_READ_U, REQ_READ_S, REQ_PEEK:
            begin
                if (width != 0)
                begin
                    if (rd_bits + width > wr_bits)
                    begin
                        sticky_overread = 1'b1;
                        stat = STAT_OVERREAD;
                    end
                    else
                    begin
                        data = fetch_field(rd_bits, width);
                        if (req == REQ_READ_S && width < MAX_FIELD && data[width-1])
                        begin
                            data |= ~((32'd1 << width) - 32'd1);
                        end
                        if (req != REQ_PEEK)
                        begin
                            rd_bits += width;
                        end
                    end
                end
            end
            REQ_SKIP:
            begin
                // A skip past the written data parks at the write pointer.
                if (rd_bits + cnt > wr_bits)
                begin
                    sticky_overread = 1'b1;
                    stat = STAT_OVERREAD;
                    rd_bits = wr_bits;
                end
                else
                begin
                    rd_bits += cnt;
                end
            end
            REQ_SET_WR:
            begin
                wr_bits = (pos > CAP_BITS) ? CAP_BITS : pos;
            end
            REQ_SET_RD:
            begin
                rd_bits = (pos > CAP_BITS) ? CAP_BITS : pos;
            end
            REQ_START:
            begin
                wr_bits = 0;
                rd_bits = 0;
                sticky_overread = 1'b0;
            end
        endcase
        r.read_data     = data;
        r.status        = stat;
        r.overread_seen = sticky_overread;
        r.write_pos     = wr_bits[CNT_W-1:0];
        r.read_pos      = rd_bits[CNT_W-1:0];
        r.at_end        = (rd_bits >= wr_bits);
        return r;
    endfunction

    // Responses are checked before requests are queued, since a response can
    // never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_BYTES; i++)
            begin
                stream_bytes[i] = 8'h00;
            end
            wr_bits = 0;
            rd_bits = 0;
            sticky_overread = 1'b0;
            expected_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    report_mismatch("response transfer with no request outstanding");
                end
                else
                begin
                    expected = expected_responses.pop_front();
                    observed = '{read_data, status, overread_seen, write_pos, read_pos, at_end};
                    if (observed.read_data !== expected.read_data)
                    begin
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  observed.read_data, expected.read_data));
                    end
                    if (observed.status !== expected.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  observed.status, expected.status));
                    end
                    if (observed.overread_seen !== expected.overread_seen)
                    begin
                        report_mismatch($sformatf("overread_seen %b, expected %b",
                                                  observed.overread_seen,
                                                  expected.overread_seen));
                    end
                    if (observed.write_pos !== expected.write_pos)
                    begin
                        report_mismatch($sformatf("write_pos %0d, expected %0d",
                                                  observed.write_pos, expected.write_pos));
                    end
                    if (observed.read_pos !== expected.read_pos)
                    begin
                        report_mismatch($sformatf("read_pos %0d, expected %0d",
                                                  observed.read_pos, expected.read_pos));
                    end
                    if (observed.at_end !== expected.at_end)
                    begin
                        report_mismatch($sformatf("at_end %b, expected %b",
                                                  observed.at_end, expected.at_end));
                    end
                    response_index++;
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_responses.push_back(apply_request(req_type, bit_count,
                                                           value, position));
            end
            outstanding <= expected_responses.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Drives requests into the bit field buffer and gives the final verdict; the
// checker beside the block predicts and compares every response.
module testbench;

    import bfp_pkg::*;

    localparam int BUF_BYTES    = 1024;
    localparam int CAP_BITS     = BUF_BYTES * 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [REQ_W-1:0]  req_type;
    logic [CNT_W-1:0]  bit_count;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  position;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic              overread_seen;
    logic [CNT_W-1:0]  write_pos;
    logic [CNT_W-1:0]  read_pos;
    logic              at_end;
    int unsigned       failures;
    int unsigned       outstanding;

    // Pointer tracking on the stimulus side, used only to keep reads inside
    // bits that have been written since reset.
    int          trk_wr = 0;
    int          trk_rd = 0;
    int          written_limit = 0;
    int unsigned accepted_count = 0;
    bit          hold_done = 1'b0;

    bit_field_pack_unpack_buffer #(
        .BUF_BYTES(BUF_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .bit_count(bit_count),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .status(status),
        .overread_seen(overread_seen),
        .write_pos(write_pos),
        .read_pos(read_pos),
        .at_end(at_end)
    );

    bit_field_checker #(
        .BUF_BYTES(BUF_BYTES)
    ) field_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .bit_count(bit_count),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .status(status),
        .overread_seen(overread_seen),
        .write_pos(write_pos),
        .read_pos(read_pos),
        .at_end(at_end),
        .failures(failures),
        .outstanding(outstanding)
    );

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard limit on the run.
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    // Offers one request and waits for its transfer; reads that would touch
    // bits never written become skips.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CNT_W-1:0] cnt,
                                input logic [DATA_W-1:0] val, input logic [CNT_W-1:0] pos);
        int width;
        width = (cnt > MAX_FIELD) ? MAX_FIELD : cnt;
        if ((req == REQ_READ_U || req == REQ_READ_S || req == REQ_PEEK) && width != 0
            && trk_rd + width <= trk_wr && trk_rd + width > written_limit)
        begin
            req = REQ_SKIP;
        end
        case (req)
            REQ_WRITE:
            begin
                if (width != 0 && trk_wr + width <= CAP_BITS)
                begin
                    if (trk_wr <= written_limit && trk_wr + width > written_limit)
                    begin
                        written_limit = trk_wr + width;
                    end
                    trk_wr += width;
                end
            end
            REQ_READ_U, REQ_READ_S:
            begin
                if (width != 0 && trk_rd + width <= trk_wr)
                begin
                    trk_rd += width;
                end
            end
            REQ_SKIP:
            begin
                trk_rd = (trk_rd + cnt > trk_wr) ? trk_wr : trk_rd + cnt;
            end
            REQ_SET_WR:
            begin
                trk_wr = (pos > CAP_BITS) ? CAP_BITS : pos;
            end
            REQ_SET_RD:
            begin
                trk_rd = (pos > CAP_BITS) ? CAP_BITS : pos;
            end
            REQ_START:
            begin
                trk_wr = 0;
                trk_rd = 0;
            end
            default:
            begin
            end
        endcase
        in_valid  <= 1'b1;
        req_type  <= req;
        bit_count <= cnt;
        value     <= val;
        position  <= pos;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        accepted_count++;
    endtask

    // Drops valid for a number of cycles.
    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the sender until every expected response has arrived or the wait gives up.
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end while (outstanding != 0 && waited < 20000);
    endtask

    // Field width for writes and reads, mostly inside the clamp.
    function automatic logic [CNT_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return '0;
        end
        else if (r < 92)
        begin
            return CNT_W'($urandom_range(1, MAX_FIELD));
        end
        return CNT_W'($urandom_range(33, 16383));
    endfunction

    // Width that mostly fits in the unread part of the stream.
    function automatic logic [CNT_W-1:0] pick_read_width();
        int avail;
        avail = trk_wr - trk_rd;
        if (avail > 0 && $urandom_range(0, 99) < 80)
        begin
            return CNT_W'($urandom_range(1, (avail < MAX_FIELD) ? avail : MAX_FIELD));
        end
        return pick_width();
    endfunction

    // One random request; writes are the most frequent kind so that reads find data to return.
    task automatic send_random_request();
        int                r;
        int                avail;
        logic [REQ_W-1:0]  req;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  pos;
        r     = $urandom_range(0, 99);
        cnt   = CNT_W'($urandom_range(0, 16383));
        pos   = CNT_W'($urandom_range(0, 16383));
        avail = trk_wr - trk_rd;
        if (r < 38)
        begin
            req = REQ_WRITE;
            cnt = pick_width();
        end
        else if (r < 80)
        begin
            req = (r < 56) ? REQ_READ_U : ((r < 72) ? REQ_READ_S : REQ_PEEK);
            cnt = pick_read_width();
        end
        else if (r < 86)
        begin
            req = REQ_SKIP;
            if ($urandom_range(0, 99) < 70)
            begin
                cnt = CNT_W'($urandom_range(0, (avail > 0) ? avail : 0));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                cnt = CNT_W'($urandom_range(0, 64));
            end
        end
        else if (r < 90)
        begin
            req = REQ_SET_WR;
            case ($urandom_range(0, 9))
                0, 1:    pos = CNT_W'($urandom_range(CAP_BITS - 100, CAP_BITS));
                2:       pos = CNT_W'($urandom_range(0, CAP_BITS));
                3:       pos = CNT_W'($urandom_range(0, 16383));
                default: pos = CNT_W'($urandom_range(0, written_limit));
            endcase
        end
        else if (r < 95)
        begin
            req = REQ_SET_RD;
            if ($urandom_range(0, 99) < 70)
            begin
                pos = CNT_W'($urandom_range(0, (trk_wr < CAP_BITS) ? trk_wr : CAP_BITS));
            end
        end
        else
        begin
            req = REQ_START;
        end
        send_request(req, cnt, $urandom(), pos);
    endtask

    // Receiver stall patterns, with one long hold-off once traffic is going.
    initial
    begin
        int mode;
        int len;
        int phase;
        out_stall <= 1'b0;
        phase = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 200);
            repeat (len)
            begin
                @(posedge clk);
                phase = (phase + 1) % 7;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ($urandom_range(0, 9) < 8);
                    default: out_stall <= (phase < 3);
                endcase
            end
        end
    end

    // Reset, directed requests, random bursts, then the verdict.
    initial
    begin
        int sent;
        int burst;
        bit paused;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_WRITE;
        bit_count = '0;
        value     = '0;
        position  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero widths change nothing.
        send_request(REQ_WRITE,  14'd0, 32'hFFFF_FFFF, 14'd0);
        send_request(REQ_READ_U, 14'd0, 32'h0, 14'd0);
        send_request(REQ_PEEK,   14'd0, 32'h0, 14'd0);
        send_request(REQ_SKIP,   14'd0, 32'h0, 14'd0);
        // Over-read on an empty stream sets the sticky flag; start over clears it.
        send_request(REQ_READ_U, 14'd8, 32'h0, 14'd0);
        send_request(REQ_START,  14'd0, 32'h0, 14'd0);
        // Full-width, clamped and masked writes.
        send_request(REQ_WRITE,  14'd32, 32'hFFFF_FFFF, 14'd0);
        send_request(REQ_WRITE,  14'd40, 32'hA5A5_5A5A, 14'd0);
        send_request(REQ_WRITE,  14'd1,  32'h0000_0001, 14'd0);
        send_request(REQ_WRITE,  14'd7,  32'hFFFF_FF2A, 14'd0);
        // Read them back: peek, signed full width, clamped width, one- and seven-bit signed, then an over-read.
        send_request(REQ_PEEK,   14'd32, 32'h0, 14'd0);
        send_request(REQ_READ_S, 14'd32, 32'h0, 14'd0);
        send_request(REQ_READ_U, 14'd40, 32'h0, 14'd0);
        send_request(REQ_READ_S, 14'd1,  32'h0, 14'd0);
        send_request(REQ_READ_S, 14'd7,  32'h0, 14'd0);
        send_request(REQ_READ_U, 14'd1,  32'h0, 14'd0);
        // Over-skip parks at the write pointer.
        send_request(REQ_SET_RD, 14'd0,    32'h0, 14'd0);
        send_request(REQ_SKIP,   14'd8191, 32'h0, 14'd0);
        // Pointers set beyond capacity saturate.
        send_request(REQ_SET_RD, 14'd0, 32'h0, 14'd16383);
        send_request(REQ_READ_U, 14'd1, 32'h0, 14'd0);
        send_request(REQ_SET_WR, 14'd0, 32'h0, 14'd16383);
        send_request(REQ_WRITE,  14'd1, 32'h1, 14'd0);
        // A write that exactly fills the store, then one that does not fit.
        send_request(REQ_SET_WR, 14'd0,  32'h0, CNT_W'(CAP_BITS - 32));
        send_request(REQ_WRITE,  14'd32, 32'h8000_0001, 14'd0);
        send_request(REQ_WRITE,  14'd1,  32'h0, 14'd0);
        send_request(REQ_SKIP,   14'd16383, 32'h0, 14'd8192);
        send_request(REQ_START,  14'd0, 32'h0, 14'd0);
        wait_drained();

        // Random traffic in bursts with gaps of random length.
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send_random_request();
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                idle_sender($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            if (outstanding != 0)
            begin
                $display("%0d responses never arrived", outstanding);
            end
            $display("simulation failed");
        end
        $finish;
    end

endmodule
